FILE: sv/double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// double_ended_queue_macros.svh
// assertion helpers for the deque top level, sampled on clk_i, off in reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types and codes of the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned VALUE_W          = 32;
  localparam int unsigned OP_W             = 2;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned COUNT_OUT_W      = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic respond;
  } deq_cmd_t;

endpackage

`default_nettype wire

FILE: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values held in a ring buffer
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Its result shows
// on the result ports for one cycle under result_valid_o, in the result state
// that follows the execute state. The receiver cannot stall it, so it must
// take the result in that cycle. Each item runs through the controller
// sequence: capture, one store access with a registered read, result cycle.
// entry_count_o carries the low five bits of the fill count.
`default_nettype none

`include "double_ended_queue_macros.svh"

module double_ended_queue #(
  parameter int unsigned CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic        [deq_pkg::OP_W-1:0]        operation_i,
  input  wire logic signed [deq_pkg::VALUE_W-1:0]     push_value_i,
  output logic                                        result_valid_o,
  output logic signed      [deq_pkg::VALUE_W-1:0]     removed_value_o,
  output logic             [deq_pkg::STATUS_W-1:0]    status_o,
  output logic             [deq_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  deq_pkg::deq_cmd_t cmd;

  logic accept;
  logic step_failed;
  logic status_known;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (operation_i),
    .push_value_i    (push_value_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o)
  );

  assign result_valid_o = cmd.respond;

  assign accept       = start && !busy;
  assign step_failed  = result_valid_o && (status_o != deq_pkg::ST_OK);
  assign status_known = (status_o == deq_pkg::ST_OK) ||
                        (status_o == deq_pkg::ST_EMPTY) ||
                        (status_o == deq_pkg::ST_FULL);

  `DEQ_ASSERT_NEXT(a_accept_busy, accept, busy && !result_valid_o, "busy not raised")
  `DEQ_ASSERT_NEXT(a_result_latency, accept, ##1 result_valid_o, "result strobe late")
  `DEQ_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o && !busy, "long strobe")
  `DEQ_ASSERT_SAME(a_failed_zero, step_failed, removed_value_o == '0, "failed step value")
  `DEQ_ASSERT_SAME(a_status_code, result_valid_o, status_known, "bad status code")

endmodule

`default_nettype wire

FILE: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer: accept, memory access, result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  output deq_pkg::deq_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start;
  assign cmd_o.execute = (state_q == S_EXEC);
  assign cmd_o.respond = (state_q == S_RESP);

endmodule

`default_nettype wire

FILE: sv/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// ring buffer store, head pointer, fill count and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath #(
  parameter int unsigned CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  deq_pkg::deq_cmd_t                           cmd_i,
  input  wire logic        [deq_pkg::OP_W-1:0]        operation_i,
  input  wire logic signed [deq_pkg::VALUE_W-1:0]     push_value_i,
  output logic signed      [deq_pkg::VALUE_W-1:0]     removed_value_o,
  output logic             [deq_pkg::STATUS_W-1:0]    status_o,
  output logic             [deq_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned EXT_W = CNT_W + deq_pkg::COUNT_OUT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] CAP_SUM  = SUM_W'(CAPACITY);

  logic [deq_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [deq_pkg::OP_W-1:0]     op_q;
  logic [deq_pkg::VALUE_W-1:0]  value_q;
  logic [deq_pkg::VALUE_W-1:0]  rd_q;
  logic [IDX_W-1:0]             head_q, head_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [deq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         pop_ok_q, pop_ok_d;

  logic             is_push, full, empty, wr_en;
  logic [IDX_W-1:0] head_dec, head_inc, addr, ring_idx;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] ring_sum;
  logic [EXT_W-1:0] count_ext;

  assign is_push = (op_q == deq_pkg::OP_PUSH_FRONT) || (op_q == deq_pkg::OP_PUSH_BACK);
  assign full    = (count_q == FULL_CNT);
  assign empty   = (count_q == '0);

  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;

  // back slot: head + count for a push, head + count - 1 for a pop
  assign offset   = (op_q == deq_pkg::OP_PUSH_BACK) ? count_q : count_q - 1'b1;
  assign ring_sum = SUM_W'(head_q) + SUM_W'(offset);
  always_comb begin
    if (ring_sum >= CAP_SUM) begin
      ring_idx = IDX_W'(ring_sum - CAP_SUM);
    end else begin
      ring_idx = IDX_W'(ring_sum);
    end
  end

  always_comb begin
    case (op_q)
      deq_pkg::OP_PUSH_FRONT: addr = head_dec;
      deq_pkg::OP_POP_FRONT:  addr = head_q;
      default:                addr = ring_idx;
    endcase
  end

  assign wr_en = cmd_i.execute && is_push && !full;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    if (cmd_i.execute) begin
      status_d = deq_pkg::ST_OK;
      pop_ok_d = 1'b0;
      if (is_push) begin
        if (full) begin
          status_d = deq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          if (op_q == deq_pkg::OP_PUSH_FRONT) head_d = head_dec;
        end
      end else begin
        if (empty) begin
          status_d = deq_pkg::ST_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          count_d  = count_q - 1'b1;
          if (op_q == deq_pkg::OP_POP_FRONT) head_d = head_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= deq_pkg::ST_OK;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      value_q <= push_value_i;
    end
  end

  // single-port store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[addr] <= value_q;
    if (cmd_i.execute) rd_q <= mem[addr];
  end

  assign count_ext       = EXT_W'(count_q);
  assign removed_value_o = (cmd_i.respond && pop_ok_q) ? $signed(rd_q) : '0;
  assign status_o        = status_q;
  assign entry_count_o   = count_ext[deq_pkg::COUNT_OUT_W-1:0];

endmodule

`default_nettype wire

FILE: sim/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// self-checking bench for the ring buffer deque
// ----------------------------------------------------------------------------
// A driver feeds operations from a backlog at the falling edge; a monitor at
// the rising edge tracks each transfer through a shadow deque and checks
// every result strobe against the oldest predicted reply. A directed
// sequence covers empty pops, pushes into an empty queue and a full queue;
// random traffic then swings between push-heavy, balanced and pop-heavy
// stretches under three sender idle profiles.

module double_ended_queue_tb;

  localparam int unsigned CAP     = deq_pkg::DEFAULT_CAPACITY;
  localparam int unsigned MARGIN  = 10;

  typedef struct {
    logic        [deq_pkg::OP_W-1:0]    op;
    logic signed [deq_pkg::VALUE_W-1:0] value;
  } deq_op_t;

  typedef struct {
    logic signed [deq_pkg::VALUE_W-1:0]     removed;
    logic        [deq_pkg::STATUS_W-1:0]    status;
    logic        [deq_pkg::COUNT_OUT_W-1:0] count;
  } deq_reply_t;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  start = 1'b0;
  logic                                  busy;
  logic        [deq_pkg::OP_W-1:0]        operation_i = deq_pkg::OP_PUSH_FRONT;
  logic signed [deq_pkg::VALUE_W-1:0]     push_value_i = '0;
  logic                                  result_valid_o;
  logic signed [deq_pkg::VALUE_W-1:0]     removed_value_o;
  logic        [deq_pkg::STATUS_W-1:0]    status_o;
  logic        [deq_pkg::COUNT_OUT_W-1:0] entry_count_o;

  deq_op_t     op_backlog[$];
  deq_reply_t  due_replies[$];
  int unsigned idle_pct = 0;
  int unsigned fail_count = 0;
  logic        took = 1'b0;

  // shadow deque
  logic signed [deq_pkg::VALUE_W-1:0] shadow_ring [CAP];
  int unsigned                        shadow_head = 0;
  int unsigned                        shadow_fill = 0;

  double_ended_queue DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_valid_o (result_valid_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic deq_reply_t apply_deque_op(deq_op_t item);
    deq_reply_t r;
    r.removed = '0;
    r.status  = deq_pkg::ST_OK;
    if (item.op == deq_pkg::OP_PUSH_FRONT || item.op == deq_pkg::OP_PUSH_BACK) begin
      if (shadow_fill >= CAP) begin
        r.status = deq_pkg::ST_FULL;
      end else if (item.op == deq_pkg::OP_PUSH_FRONT) begin
        shadow_head = (shadow_head + CAP - 1) % CAP;
        shadow_ring[shadow_head] = item.value;
        shadow_fill++;
      end else begin
        shadow_ring[(shadow_head + shadow_fill) % CAP] = item.value;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = deq_pkg::ST_EMPTY;
      end else if (item.op == deq_pkg::OP_POP_FRONT) begin
        r.removed = shadow_ring[shadow_head];
        shadow_head = (shadow_head + 1) % CAP;
        shadow_fill--;
      end else begin
        r.removed = shadow_ring[(shadow_head + shadow_fill - 1) % CAP];
        shadow_fill--;
      end
    end
    r.count = shadow_fill[deq_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [deq_pkg::OP_W-1:0] op,
                          logic signed [deq_pkg::VALUE_W-1:0] value);
    deq_op_t item;
    item.op    = op;
    item.value = value;
    op_backlog.push_back(item);
  endtask

  // random traffic in stretches biased toward filling, balanced, or biased toward draining
  task automatic queue_random(int unsigned n);
    int unsigned push_pct;
    logic [deq_pkg::OP_W-1:0] op;
    push_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
      end
      queue_op(op, pick_value());
    end
  endtask

  task automatic drain();
    while (op_backlog.size() != 0 || start || due_replies.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    deq_op_t item;
    if (rst_ni && (!start || took)) begin
      if (op_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        item = op_backlog.pop_front();
        start        <= 1'b1;
        operation_i  <= item.op;
        push_value_i <= item.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    deq_reply_t exp_r;
    deq_op_t    item;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_replies.size() == 0) begin
          $display("%0t: result with none expected: removed %0d status %0d count %0d",
                   $time, removed_value_o, status_o, entry_count_o);
          fail_count++;
        end else begin
          exp_r = due_replies.pop_front();
          if (removed_value_o !== exp_r.removed) begin
            $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                     $time, exp_r.removed, removed_value_o);
            fail_count++;
          end
          if (status_o !== exp_r.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_r.status, status_o);
            fail_count++;
          end
          if (entry_count_o !== exp_r.count) begin
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, exp_r.count, entry_count_o);
            fail_count++;
          end
        end
      end
      took = start && !busy;
      if (took) begin
        item.op    = operation_i;
        item.value = push_value_i;
        due_replies.push_back(apply_deque_op(item));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed: empty pops, push into empty, last entry out, wrap, full
    idle_pct = 26;
    queue_op(deq_pkg::OP_POP_FRONT, 32'sh1234_5678);
    queue_op(deq_pkg::OP_POP_BACK, '1);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
    queue_op(deq_pkg::OP_POP_BACK, '0);
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    queue_op(deq_pkg::OP_POP_FRONT, '0);
    queue_op(deq_pkg::OP_PUSH_FRONT, '1);
    for (int i = 0; i < 15; i++) begin
      queue_op((i % 2) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT, pick_value());
    end
    queue_op(deq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
    queue_op(deq_pkg::OP_PUSH_BACK, 32'shaaaa_aaaa);
    queue_random(500);
    // sender holds off until every reply is back
    drain();

    idle_pct = 85;
    queue_random(520);
    drain();

    idle_pct = 0;
    queue_random(530);
    drain();

    repeat (MARGIN) @(posedge clk_i);
    if (fail_count == 0 && due_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
